/* hdl/qslerp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package qslerp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN = 24;
  localparam int CV_W = 34;

  typedef logic signed [CV_W-1:0] cval_t;

  localparam cval_t ONE_Q30 = 34'sd1073741824;
  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [30:0] DOT_ONE = 31'h4000_0000;

  function automatic cval_t atan_q30(input int unsigned idx);
    cval_t v;
    unique case (idx)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837830;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/quaternion_slerp_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle; the depth is set by the sine square-root
// pipeline, the CORDIC chains and the 33-stage weight divider.
// A stall on the output holds the whole pipeline in place.
// Reset (synchronous, rst_n low) clears all valid bits and sets the threshold to 1.
module quaternion_slerp_top #(
  parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_a_x,
  input  logic signed [15:0] in_a_y,
  input  logic signed [15:0] in_a_z,
  input  logic signed [15:0] in_a_w,
  input  logic signed [15:0] in_b_x,
  input  logic signed [15:0] in_b_y,
  input  logic signed [15:0] in_b_z,
  input  logic signed [15:0] in_b_w,
  input  logic [16:0]        in_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_r_x,
  output logic signed [15:0] out_r_y,
  output logic signed [15:0] out_r_z,
  output logic signed [15:0] out_r_w,
  output logic               out_used_linear
);

  localparam int S      = CORDIC_STEPS;
  localparam int SINE_W = 31;
  localparam int NORM_W = 25;
  localparam int WQ_W   = 33;
  localparam int LQ_W   = 16;
  localparam int L_SINE = 3 + SINE_W;
  localparam int L_ANG  = L_SINE + S;
  localparam int L_DIV  = L_ANG + 2 + S;
  localparam int L_W    = L_DIV + 1 + WQ_W + 1;
  localparam int LAT    = L_W + 2;
  localparam int L_LIN  = 6 + NORM_W + LQ_W + 1;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic [14:0]    thr_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= 15'd1;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // stage 1: products for the dot, clamp t
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];
  logic signed [15:0] a1_r [4];
  logic signed [15:0] b1_r [4];
  logic signed [31:0] p1_r [4];
  logic [16:0]        t1_r;

  assign in_a = '{in_a_x, in_a_y, in_a_z, in_a_w};
  assign in_b = '{in_b_x, in_b_y, in_b_z, in_b_w};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a1_r[i] <= in_a[i];
        b1_r[i] <= in_b[i];
        p1_r[i] <= in_a[i] * in_b[i];
      end
      t1_r <= (in_fraction > qslerp_pkg::T_ONE) ? qslerp_pkg::T_ONE : in_fraction;
    end
  end

  // stage 2: dot sum, short-arc flip, clamp
  logic signed [33:0] dot2, dabs2;
  logic signed [15:0] a2_r  [4];
  logic signed [16:0] bf2_r [4];
  logic [16:0]        t2_r;
  logic [30:0]        dot2_r;

  always_comb begin
    dot2  = 34'(p1_r[0]) + 34'(p1_r[1]) + 34'(p1_r[2]) + 34'(p1_r[3]);
    dabs2 = dot2[33] ? -dot2 : dot2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a2_r[i]  <= a1_r[i];
        bf2_r[i] <= dot2[33] ? -(17'(b1_r[i])) : 17'(b1_r[i]);
      end
      t2_r   <= t1_r;
      dot2_r <= (dabs2 > 34'sd1073741824) ? qslerp_pkg::DOT_ONE : dabs2[30:0];
    end
  end

  // stage 3: dot squared, t*(b-a)
  logic [61:0]        sq3_r;
  logic signed [35:0] lp3_r [4];
  logic signed [15:0] a3_r  [4];
  logic signed [16:0] bf3_r [4];
  logic [16:0]        t3_r;
  logic [30:0]        dot3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq3_r <= dot2_r * dot2_r;
      for (int i = 0; i < 4; i++) begin
        lp3_r[i] <= $signed({1'b0, t2_r}) * (18'(bf2_r[i]) - 18'(a2_r[i]));
        a3_r[i]  <= a2_r[i];
        bf3_r[i] <= bf2_r[i];
      end
      t3_r   <= t2_r;
      dot3_r <= dot2_r;
    end
  end

  // sine = sqrt(1 - dot^2)
  logic [61:0]       sine_rad;
  logic [SINE_W-1:0] sine;

  assign sine_rad = 62'h1000_0000_0000_0000 - sq3_r;

  qslerp_isqrt #(.OUT_W(SINE_W)) u_sine_sqrt (
    .clk (clk),
    .en  (en),
    .din (sine_rad),
    .dout(sine)
  );

  // linear path: stage 4 lerp, stage 5 squares, stage 6 sum
  logic signed [35:0] pre4  [4];
  logic signed [24:0] l4_r  [4];
  logic signed [49:0] lsq5  [4];
  logic [47:0]        lsq5_r [4];
  logic [2*NORM_W-1:0] n2_6_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pre4[i] = (36'(a3_r[i]) <<< 16) + lp3_r[i];
      lsq5[i] = l4_r[i] * l4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        l4_r[i]   <= pre4[i][32:8];
        lsq5_r[i] <= lsq5[i][47:0];
      end
      n2_6_r <= 50'(lsq5_r[0]) + 50'(lsq5_r[1]) + 50'(lsq5_r[2]) + 50'(lsq5_r[3]);
    end
  end

  logic [NORM_W-1:0] norm;

  qslerp_isqrt #(.OUT_W(NORM_W)) u_norm_sqrt (
    .clk (clk),
    .en  (en),
    .din (n2_6_r),
    .dout(norm)
  );

  logic [99:0]        l_pack, l_dpack;
  logic signed [24:0] l_d  [4];
  logic [24:0]        lmag [4];
  logic [4:0]         lsb_in, lsb_d;
  logic [LQ_W-1:0]    lq   [4];
  logic [15:0]        lin48_r [4];
  logic [63:0]        lin_pack, lin_dpack;
  logic [15:0]        lres_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      l_pack[i*25 +: 25] = l4_r[i];
      l_d[i]             = $signed(l_dpack[i*25 +: 25]);
      lmag[i]            = l_d[i][24] ? 25'(-l_d[i]) : 25'(l_d[i]);
      lsb_in[i]          = l_d[i][24];
      lin_pack[i*16 +: 16] = lin48_r[i];
      lres_d[i]          = lin_dpack[i*16 +: 16];
    end
    lsb_in[4] = (norm == '0);
  end

  qslerp_delay #(.W(100), .D(L_SINE - 3 - NORM_W + 3 + (NORM_W - SINE_W) + 24))
    u_l_dly (.clk(clk), .en(en), .din(l_pack), .dout(l_dpack));

  for (genvar i = 0; i < 4; i++) begin : g_ldiv
    qslerp_div #(.NUM_W(39), .DEN_W(NORM_W), .Q_W(LQ_W)) u_div (
      .clk(clk),
      .en (en),
      .num({lmag[i][23:0], 15'b0}),
      .den(norm),
      .quo(lq[i])
    );
  end

  qslerp_delay #(.W(5), .D(LQ_W))
    u_lsb_dly (.clk(clk), .en(en), .din(lsb_in), .dout(lsb_d));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (lsb_d[4]) begin
          lin48_r[i] <= '0;
        end else if (lsb_d[i]) begin
          lin48_r[i] <= -lq[i];
        end else begin
          lin48_r[i] <= lq[i][15] ? 16'h7fff : lq[i];
        end
      end
    end
  end

  qslerp_delay #(.W(64), .D(L_W + 1 - L_LIN))
    u_lin_dly (.clk(clk), .en(en), .din(lin_pack), .dout(lin_dpack));

  // angle path
  logic [30:0]       dot_d;
  logic [16:0]       t_d;
  qslerp_pkg::cval_t ang, sden, sden_d, sn1, sn2;
  logic              low_sine, low_sine_d, lin_in, lin_d;

  qslerp_delay #(.W(31), .D(SINE_W))
    u_dot_dly (.clk(clk), .en(en), .din(dot3_r), .dout(dot_d));

  qslerp_delay #(.W(17), .D(L_ANG - 3))
    u_t_dly (.clk(clk), .en(en), .din(t3_r), .dout(t_d));

  qslerp_cordic #(.STEPS(S), .VECTOR(1'b1)) u_vec (
    .clk  (clk),
    .en   (en),
    .x_in ($signed({3'b0, dot_d})),
    .y_in ($signed({3'b0, sine})),
    .z_in ('0),
    .x_out(),
    .y_out(),
    .z_out(ang)
  );

  assign low_sine = sine <= {1'b0, thr_r, 15'b0};

  qslerp_delay #(.W(1), .D(2 * S))
    u_low_sine_dly (.clk(clk), .en(en), .din(low_sine), .dout(low_sine_d));

  qslerp_cordic #(.STEPS(S), .VECTOR(1'b0)) u_sden (
    .clk  (clk),
    .en   (en),
    .x_in (qslerp_pkg::ONE_Q30),
    .y_in ('0),
    .z_in (ang),
    .x_out(),
    .y_out(sden),
    .z_out()
  );

  assign lin_in = low_sine_d || (sden <= 0);

  qslerp_delay #(.W(1), .D(LAT - 1 - (L_ANG + S)))
    u_lflag_dly (.clk(clk), .en(en), .din(lin_in), .dout(lin_d));

  qslerp_delay #(.W(34), .D(2))
    u_sden_dly (.clk(clk), .en(en), .din(sden), .dout(sden_d));

  // partial angles
  logic signed [51:0] pa1_r;
  qslerp_pkg::cval_t  ang1_r, phi1_r, phi2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r  <= $signed({1'b0, t_d}) * ang;
      ang1_r <= ang;
      phi2_r <= $signed(pa1_r[49:16]);
      phi1_r <= ang1_r - $signed(pa1_r[49:16]);
    end
  end

  qslerp_cordic #(.STEPS(S), .VECTOR(1'b0)) u_sin1 (
    .clk  (clk),
    .en   (en),
    .x_in (qslerp_pkg::ONE_Q30),
    .y_in ('0),
    .z_in (phi1_r),
    .x_out(),
    .y_out(sn1),
    .z_out()
  );

  qslerp_cordic #(.STEPS(S), .VECTOR(1'b0)) u_sin2 (
    .clk  (clk),
    .en   (en),
    .x_in (qslerp_pkg::ONE_Q30),
    .y_in ('0),
    .z_in (phi2_r),
    .x_out(),
    .y_out(sn2),
    .z_out()
  );

  // weight division setup: magnitudes, signs, overflow past the clamp
  qslerp_pkg::cval_t sn [2];
  qslerp_pkg::cval_t smag [2];
  logic [31:0]       mag_r [2];
  logic [31:0]       den_r;
  logic [3:0]        wsb_r, wsb_d;
  logic [WQ_W-1:0]   wq [2];

  assign sn = '{sn1, sn2};

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      smag[j] = sn[j][33] ? -sn[j] : sn[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        mag_r[j]      <= smag[j][31:0];
        wsb_r[2*j]    <= sn[j][33];
        wsb_r[2*j+1]  <= {3'b0, $unsigned(smag[j])} >= {$unsigned(sden_d), 3'b000};
      end
      den_r <= sden_d[31:0];
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_wdiv
    qslerp_div #(.NUM_W(62), .DEN_W(32), .Q_W(WQ_W)) u_div (
      .clk(clk),
      .en (en),
      .num({mag_r[j], 30'b0}),
      .den(den_r),
      .quo(wq[j])
    );
  end

  qslerp_delay #(.W(4), .D(WQ_W))
    u_wsb_dly (.clk(clk), .en(en), .din(wsb_r), .dout(wsb_d));

  logic [WQ_W-1:0]   wqc [2];
  qslerp_pkg::cval_t w_r [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      wqc[j] = (wsb_d[2*j+1] || (wq[j] > 33'h1_0000_0000)) ? 33'h1_0000_0000 : wq[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        w_r[j] <= wsb_d[2*j] ? -$signed({1'b0, wqc[j]}) : $signed({1'b0, wqc[j]});
      end
    end
  end

  // operands for the weighted sum
  logic [131:0]       ab_pack, ab_dpack;
  logic signed [15:0] a_d  [4];
  logic signed [16:0] bf_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ab_pack[i*16 +: 16]      = a3_r[i];
      ab_pack[64 + i*17 +: 17] = bf3_r[i];
      a_d[i]                   = $signed(ab_dpack[i*16 +: 16]);
      bf_d[i]                  = $signed(ab_dpack[64 + i*17 +: 17]);
    end
  end

  qslerp_delay #(.W(132), .D(L_W - 3))
    u_ab_dly (.clk(clk), .en(en), .din(ab_pack), .dout(ab_dpack));

  logic signed [49:0] m1_r [4];
  logic signed [50:0] m2_r [4];
  logic signed [51:0] fsum [4];
  logic signed [21:0] fsh  [4];
  logic signed [15:0] slerp [4];
  logic signed [15:0] res_r [4];
  logic               lin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        m1_r[i] <= w_r[0] * a_d[i];
        m2_r[i] <= w_r[1] * bf_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fsum[i] = 52'(m1_r[i]) + 52'(m2_r[i]) + 52'sd536870912;
      fsh[i]  = $signed(fsum[i][51:30]);
      if (fsh[i] > 22'sd32767) begin
        slerp[i] = 16'sh7fff;
      end else if (fsh[i] < -22'sd32768) begin
        slerp[i] = -16'sh8000;
      end else begin
        slerp[i] = fsh[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        res_r[i] <= lin_d ? $signed(lres_d[i]) : slerp[i];
      end
      lin_r <= lin_d;
    end
  end

  assign out_r_x         = res_r[0];
  assign out_r_y         = res_r[1];
  assign out_r_z         = res_r[2];
  assign out_r_w         = res_r[3];
  assign out_used_linear = lin_r;

endmodule
`default_nettype wire

/* hdl/qslerp_delay.sv */
`timescale 1ns / 1ps
`default_nettype none
module qslerp_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] dly_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= din;
      for (int k = 1; k < D; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign dout = dly_r[D-1];

endmodule
`default_nettype wire

/* hdl/qslerp_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module qslerp_isqrt #(
  parameter int OUT_W = 31
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2*OUT_W-1:0] din,
  output logic [OUT_W-1:0]   dout
);

  localparam int IN_W = 2 * OUT_W;

  logic [IN_W-1:0]  rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];

  // one result bit per stage, msb first
  for (genvar k = 0; k < OUT_W; k++) begin : g_stg
    localparam int I = OUT_W - 1 - k;
    logic [IN_W-1:0]  rem_in;
    logic [OUT_W-1:0] root_in;
    logic [IN_W:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = din;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = ((IN_W+1)'(root_in) << (I + 1)) + ((IN_W+1)'(1) << (2 * I));
    assign ge    = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_in - trial[IN_W-1:0]) : rem_in;
        root_r[k] <= ge ? (root_in | (OUT_W'(1) << I)) : root_in;
      end
    end
  end

  assign dout = root_r[OUT_W-1];

endmodule
`default_nettype wire

/* hdl/qslerp_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module qslerp_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 32,
  parameter int Q_W   = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  // restoring division, one quotient bit per stage; needs num < den * 2^Q_W
  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    localparam int I = Q_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [CW-1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = CW'(den_in) << I;
    assign ge    = CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_in - trial[NUM_W-1:0]) : rem_in;
        den_r[k] <= den_in;
        q_r[k]   <= ge ? (q_in | (Q_W'(1) << I)) : q_in;
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule
`default_nettype wire

/* hdl/qslerp_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
module qslerp_cordic #(
  parameter int STEPS  = qslerp_pkg::CORDIC_STEPS_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  qslerp_pkg::cval_t x_in,
  input  qslerp_pkg::cval_t y_in,
  input  qslerp_pkg::cval_t z_in,
  output qslerp_pkg::cval_t x_out,
  output qslerp_pkg::cval_t y_out,
  output qslerp_pkg::cval_t z_out
);

  qslerp_pkg::cval_t x_r [STEPS];
  qslerp_pkg::cval_t y_r [STEPS];
  qslerp_pkg::cval_t z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stg
    qslerp_pkg::cval_t xi, yi, zi, dx, dy, at;
    logic ccw;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign at  = qslerp_pkg::atan_q30(i);
    // vectoring drives y to zero, rotation drives z to zero
    assign ccw = VECTOR ? (yi <= 0) : (zi >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (ccw) begin
          x_r[i] <= xi - dx;
          y_r[i] <= yi + dy;
          z_r[i] <= zi - at;
        end else begin
          x_r[i] <= xi + dx;
          y_r[i] <= yi - dy;
          z_r[i] <= zi + at;
        end
      end
    end
  end

  assign x_out = x_r[STEPS-1];
  assign y_out = y_r[STEPS-1];
  assign z_out = z_r[STEPS-1];

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam int STEPS = qslerp_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY = 73 + 2 * STEPS;

  typedef struct {
    logic signed [15:0] ax, ay, az, aw, bx, by, bz, bw;
    logic [16:0] t;
  } pair_t;

  typedef struct {
    logic signed [15:0] rx, ry, rz, rw;
    logic lin;
  } quat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [14:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [15:0] in_a_x = 0, in_a_y = 0, in_a_z = 0, in_a_w = 0;
  logic signed [15:0] in_b_x = 0, in_b_y = 0, in_b_z = 0, in_b_w = 0;
  logic [16:0] in_fraction = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic out_used_linear;

  quaternion_slerp_top uut (.*);

  always #10 clk = ~clk;

  pair_t pending_pairs[$];
  quat_t expected_quats[$];
  logic [14:0] sine_thresh = 15'd1;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0, n_linear = 0, n_slerp = 0, n_done = 0;

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_tab(int i);
    return longint'(qslerp_pkg::atan_q30(i));
  endfunction

  function automatic longint arc_of(longint x, longint y);
    longint z = 0, dx, dy;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab(i);
      end else begin
        x -= dx; y += dy; z -= atan_tab(i);
      end
    end
    return z;
  endfunction

  function automatic longint gain_sine(longint z);
    longint x = 64'sd1 << 30, y = 0, dx, dy;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab(i);
      end else begin
        x += dx; y -= dy; z += atan_tab(i);
      end
    end
    return y;
  endfunction

  function automatic longint clamp_w(longint w);
    longint lim = 64'sd4 << 30;
    if (w > lim) return lim;
    if (w < -lim) return -lim;
    return w;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic quat_t slerp_predict(pair_t p);
    quat_t r;
    longint a[4], b[4], l[4], res[4];
    longint dot = 0, t, sine, ang, sden, phi1, phi2, w1, w2, nrm;
    longint unsigned n2 = 0;
    logic lin;
    a[0] = p.ax; a[1] = p.ay; a[2] = p.az; a[3] = p.aw;
    b[0] = p.bx; b[1] = p.by; b[2] = p.bz; b[3] = p.bw;
    for (int i = 0; i < 4; i++) dot += a[i] * b[i];
    t = p.t;
    if (t > 65536) t = 65536;
    if (dot < 0) begin
      dot = -dot;
      for (int i = 0; i < 4; i++) b[i] = -b[i];
    end
    if (dot > (64'sd1 << 30)) dot = 64'sd1 << 30;
    sine = root64((64'd1 << 60) - longint'(dot * dot));
    ang = arc_of(dot, sine);
    sden = gain_sine(ang);
    lin = (sine <= (longint'(sine_thresh) << 15)) || (sden <= 0);
    if (lin) begin
      for (int i = 0; i < 4; i++) begin
        l[i] = shr_floor(a[i] * 65536 + t * (b[i] - a[i]), 8);
        n2 += longint'(l[i] * l[i]);
      end
      nrm = root64(n2);
      for (int i = 0; i < 4; i++)
        res[i] = (nrm == 0) ? 0 : sat16((l[i] * 32768) / nrm);
    end else begin
      phi2 = (t * ang) >>> 16;
      phi1 = ang - phi2;
      w1 = clamp_w((gain_sine(phi1) * (64'sd1 << 30)) / sden);
      w2 = clamp_w((gain_sine(phi2) * (64'sd1 << 30)) / sden);
      for (int i = 0; i < 4; i++)
        res[i] = sat16(shr_floor(w1 * a[i] + w2 * b[i] + (64'sd1 << 29), 30));
    end
    r.rx = res[0]; r.ry = res[1]; r.rz = res[2]; r.rw = res[3];
    r.lin = lin;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_valid <= 1;
          in_a_x <= p.ax; in_a_y <= p.ay; in_a_z <= p.az; in_a_w <= p.aw;
          in_b_x <= p.bx; in_b_y <= p.by; in_b_z <= p.bz; in_b_w <= p.bw;
          in_fraction <= p.t;
        end else begin
          in_valid <= 0;
        end
      end
      if (in_valid && in_ready) begin
        pair_t q;
        q.ax = in_a_x; q.ay = in_a_y; q.az = in_a_z; q.aw = in_a_w;
        q.bx = in_b_x; q.by = in_b_y; q.bz = in_b_z; q.bw = in_b_w;
        q.t = in_fraction;
        expected_quats.push_back(slerp_predict(q));
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        quat_t e;
        e = expected_quats.pop_front();
        if (out_r_x !== e.rx) begin $error("r_x exp %0d got %0d", e.rx, out_r_x); errors++; end
        if (out_r_y !== e.ry) begin $error("r_y exp %0d got %0d", e.ry, out_r_y); errors++; end
        if (out_r_z !== e.rz) begin $error("r_z exp %0d got %0d", e.rz, out_r_z); errors++; end
        if (out_r_w !== e.rw) begin $error("r_w exp %0d got %0d", e.rw, out_r_w); errors++; end
        if (out_used_linear !== e.lin) begin
          $error("used_linear exp %0d got %0d", e.lin, out_used_linear);
          errors++;
        end
        if (e.lin) n_linear++; else n_slerp++;
        n_done++;
      end
    end
  end

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [16:0] rnd_t();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // random item; unit-ish quaternions, close pairs, and noise
  function automatic pair_t rnd_pair();
    pair_t p;
    int k;
    k = $urandom_range(9);
    p.ax = rnd16(); p.ay = rnd16(); p.az = rnd16(); p.aw = rnd16();
    if (k < 4) begin
      p.ax = p.ax >>> 1; p.ay = p.ay >>> 1; p.az = p.az >>> 1; p.aw = p.aw >>> 1;
      p.bx = rnd16() >>> 1; p.by = rnd16() >>> 1; p.bz = rnd16() >>> 1; p.bw = rnd16() >>> 1;
    end else if (k < 7) begin
      p.bx = p.ax + 16'($signed($urandom_range(64)) - 32);
      p.by = p.ay + 16'($signed($urandom_range(64)) - 32);
      p.bz = p.az + 16'($signed($urandom_range(64)) - 32);
      p.bw = p.aw + 16'($signed($urandom_range(64)) - 32);
      if (k == 6) begin
        p.bx = -p.bx; p.by = -p.by; p.bz = -p.bz; p.bw = -p.bw;
      end
    end else begin
      p.bx = rnd16(); p.by = rnd16(); p.bz = rnd16(); p.bw = rnd16();
    end
    p.t = rnd_t();
    return p;
  endfunction

  function automatic pair_t mk(int ax, int ay, int az, int aw,
                               int bx, int by, int bz, int bw, int t);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.aw = aw;
    p.bx = bx; p.by = by; p.bz = bz; p.bw = bw;
    p.t = t;
    return p;
  endfunction

  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_thresh(logic [14:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sine_thresh = v;
  endtask

  task automatic run_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_pairs.push_back(rnd_pair());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;

    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 0, 32767, 32768));
    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 32767, 0, 0));
    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 32767, 0, 65536));
    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 32767, 0, 32768));
    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 32767, 0, 131071));
    pending_pairs.push_back(mk(0, 0, 0, 32767, 0, 0, 0, -32768, 16384));
    pending_pairs.push_back(mk(-32768, -32768, -32768, -32768,
                               -32768, -32768, -32768, -32768, 40000));
    pending_pairs.push_back(mk(32767, 32767, 32767, 32767,
                               -32768, -32768, -32768, -32768, 20000));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 30000));
    pending_pairs.push_back(mk(100, 0, 0, 0, -100, 0, 0, 0, 32768));
    pending_pairs.push_back(mk(16384, 16384, 16384, 16384, 16384, -16384, 16384, -16384, 1));
    pending_pairs.push_back(mk(23170, 0, 0, 23170, 23170, 0, 0, 23171, 65535));
    pending_pairs.push_back(mk(32767, 0, 0, 0, 32700, 2000, 0, 0, 20000));
    pending_pairs.push_back(mk(32767, -1, 1, 0, 0, 32767, 0, -1, 98304));
    drain();

    run_random(250, 0, 0);
    set_thresh(15'd0);
    run_random(200, 63, 0);
    set_thresh(15'd32767);
    run_random(150, 0, 63);
    set_thresh(15'd300);

    // long receiver hold-off so the pipeline fills and backs up the input
    hold_off = 400;
    run_random(300, 31, 31);
    set_thresh(15'd1);
    run_random(250, 0, 0);

    $display("checked %0d results: %0d slerp path, %0d linear path", n_done, n_slerp,
             n_linear);
    $display("thresholds 0, 1, 300 and 32767 under mixed idle and stall phases");
    if (errors == 0) begin
      $display("quaternion_slerp_top: match");
    end else begin
      $display("quaternion_slerp_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("quaternion_slerp_top: mismatch");
    $finish;
  end

endmodule
